FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/ghr_pkg.sv
// Shared types and constants for the graph hub and relay query block.
// No dependencies.
package ghr_pkg;

	localparam int KIND_W   = 2;
	localparam int NODE_W   = 5;
	localparam int WEIGHT_W = 16;
	localparam int SCORE_W  = 17;
	localparam int CFG_W    = 6;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_HUB   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELAY = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_AB,
		ST_WR_BA,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

FILE: rtl/ghr_req_if.sv
// Request channel: valid/ready plus one input item.
// Depends on ghr_pkg.
interface ghr_req_if;
	import ghr_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [NODE_W-1:0]   node_a;
	logic [NODE_W-1:0]   node_b;
	logic [WEIGHT_W-1:0] weight;

	modport source(output valid, kind, node_a, node_b, weight, input ready);
	modport sink(input valid, kind, node_a, node_b, weight, output ready);
endinterface

FILE: rtl/ghr_rsp_if.sv
// Response channel: valid/ready plus one result item.
// Depends on ghr_pkg.
interface ghr_rsp_if;
	import ghr_pkg::*;

	logic               valid;
	logic               ready;
	logic [NODE_W-1:0]  node_index;
	logic               found;
	logic [SCORE_W-1:0] score;

	modport source(output valid, node_index, found, score, input ready);
	modport sink(input valid, node_index, found, score, output ready);
endinterface

FILE: rtl/ghr_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module ghr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read (read-first)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/graph_hub_and_relay_query_top.sv
// Graph hub and relay query block. Keeps a symmetric matrix of 16-bit edge weights over
// MAX_NODES nodes in one single-port RAM; zero means no edge. After reset a clearing pass
// writes each of the 2^(2*ceil(log2(MAX_NODES))) RAM words once (1024 at 32 nodes), with
// req.ready low. An edge write is an accept plus one RAM write per direction.
// With n = min(node_count, MAX_NODES), a hub query reads n*n matrix words and a relay query
// 2*n, one matrix read per cycle through the single RAM port.
// One item is in work at a time; the result waits in an output register so the next
// item can be accepted before it is taken. Depends on ghr_pkg, ghr_req_if, ghr_rsp_if,
// ghr_ram.
module graph_hub_and_relay_query_top #(
	parameter int MAX_NODES = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ghr_pkg::CFG_W-1:0]  cfg_wdata,
	ghr_req_if.sink                    req,
	ghr_rsp_if.source                  rsp
);
	import ghr_pkg::*;

	localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW    = $clog2(MAX_NODES + 1);
	localparam int AW    = 2 * NW;
	localparam int DEPTH = 1 << AW;

	state_t state_q, state_d;

	logic [CFG_W-1:0]    node_count_q;
	logic [AW-1:0]       clr_addr_q;
	logic [KIND_W-1:0]   kind_q;
	logic [NODE_W-1:0]   a_q, b_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic                a_ok_q, b_ok_q;
	logic [CW-1:0]       n_q;
	logic [NW-1:0]       i_q, j_q;

	logic                rd_v_s1, rd_last_s1;
	logic [NW-1:0]       rd_i_s1;

	logic [SCORE_W-1:0]  acc_q, best_q;
	logic [NW-1:0]       best_node_q;
	logic                found_q;

	logic                out_valid_q;
	logic [NODE_W-1:0]   out_node_q;
	logic                out_found_q;
	logic [SCORE_W-1:0]  out_score_q;

	logic                accept, a_ok, b_ok;
	logic [CW-1:0]       n_now;
	logic                is_hub, j_last, i_last, issue, out_load;
	logic                ram_we;
	logic [AW-1:0]       ram_addr;
	logic [WEIGHT_W-1:0] ram_wdata, ram_rdata;
	logic [NW-1:0]       scan_col;

	logic                rd_ok;
	logic [WEIGHT_W-1:0] rd_w;
	logic [SCORE_W-1:0]  sum, cmp_x, cmp_y;
	logic                lt, qualifies;

	// Matrix storage
	ghr_ram #(.WIDTH(WEIGHT_W), .DEPTH(DEPTH)) u_ghr_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Input side decode
	assign accept = req.valid && req.ready;
	assign a_ok   = (32'(req.node_a) < MAX_NODES);
	assign b_ok   = (32'(req.node_b) < MAX_NODES);

	always_comb begin
		if (32'(node_count_q) > MAX_NODES) begin
			n_now = CW'(MAX_NODES);
		end else begin
			n_now = CW'(node_count_q);
		end
	end

	// Scan position: hub walks row i over columns 0..n-1, relay reads columns a then b
	assign is_hub   = (kind_q == KIND_HUB);
	assign j_last   = is_hub ? (CW'(j_q) == n_q - CW'(1)) : (j_q == NW'(1));
	assign i_last   = (CW'(i_q) == n_q - CW'(1));
	assign scan_col = is_hub ? j_q : (j_q[0] ? NW'(b_q) : NW'(a_q));

	// Sequencer: next state and RAM control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = {i_q, scan_col};
		ram_wdata = weight_q;
		issue     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					priority case (req.kind)
						KIND_WRITE: state_d = (a_ok && b_ok) ? ST_WR_AB : ST_IDLE;
						KIND_HUB,
						KIND_RELAY: state_d = (n_now == '0) ? ST_FINISH : ST_SCAN;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_WR_AB: begin
				ram_we   = 1'b1;
				ram_addr = {NW'(a_q), NW'(b_q)};
				state_d  = ST_WR_BA;
			end
			ST_WR_BA: begin
				ram_we   = 1'b1;
				ram_addr = {NW'(b_q), NW'(a_q)};
				state_d  = ST_IDLE;
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (i_last && j_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Config register and clearing-pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			clr_addr_q   <= '0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= req.kind;
			a_q      <= req.node_a;
			b_q      <= req.node_b;
			weight_q <= req.weight;
			a_ok_q   <= a_ok;
			b_ok_q   <= b_ok;
			n_q      <= n_now;
		end
	end

	// Scan counters
	always_ff @(posedge clk) begin
		if (accept) begin
			i_q <= '0;
			j_q <= '0;
		end else if (issue) begin
			if (j_last) begin
				j_q <= '0;
				i_q <= i_q + NW'(1);
			end else begin
				j_q <= j_q + NW'(1);
			end
		end
	end

	// Read tag stage, aligned with the registered RAM data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_last_s1 <= j_last;
		rd_i_s1    <= i_q;
	end

	// Shared add and compare unit
	assign rd_ok = is_hub || (rd_last_s1 ? b_ok_q : a_ok_q);
	assign rd_w  = rd_ok ? ram_rdata : '0;
	assign sum   = acc_q + (is_hub ? SCORE_W'(rd_w != '0) : SCORE_W'(rd_w));
	assign cmp_x = is_hub ? best_q : sum;
	assign cmp_y = is_hub ? sum : best_q;
	assign lt    = (cmp_x < cmp_y);
	assign qualifies = is_hub ? lt
		: ((acc_q != '0) && (rd_w != '0) && (!found_q || lt));

	// Accumulator and running best
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q       <= '0;
			best_q      <= '0;
			best_node_q <= '0;
			found_q     <= 1'b0;
		end else if (rd_v_s1) begin
			if (rd_last_s1) begin
				acc_q <= '0;
				if (qualifies) begin
					best_q      <= sum;
					best_node_q <= rd_i_s1;
					found_q     <= 1'b1;
				end
			end else begin
				acc_q <= is_hub ? sum : SCORE_W'(rd_w);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_node_q  <= NODE_W'(best_node_q);
			out_found_q <= found_q;
			out_score_q <= best_q;
		end
	end

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.node_index = out_node_q;
	assign rsp.found      = out_found_q;
	assign rsp.score      = out_score_q;

endmodule

FILE: rtl/ghr_checker.sv
// Port-level checker for the graph hub and relay query block, with its bind.
// Depends on ghr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ghr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic [ghr_pkg::KIND_W-1:0]   req_kind,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [ghr_pkg::NODE_W-1:0]   rsp_node_index,
	input logic                         rsp_found,
	input logic [ghr_pkg::SCORE_W-1:0]  rsp_score
);
	import ghr_pkg::*;

	logic query_xfer, rsp_stall;

	assign query_xfer = req_valid && req_ready
		&& (req_kind == KIND_HUB || req_kind == KIND_RELAY);
	assign rsp_stall  = rsp_valid && !rsp_ready;

	// A stalled result holds
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp_score) && $stable(rsp_found) && $stable(rsp_node_index))
	// Not found reports node 0 and score 0
	`ASSERT_IMPLY(a_notfound_zero, clk, arst_n, rsp_valid && !rsp_found, rsp_node_index == '0 && rsp_score == '0)
	// A found hub or relay always has a nonzero score
	`ASSERT_IMPLY(a_found_score, clk, arst_n, rsp_valid && rsp_found, rsp_score != '0)
	// A query transfer keeps the block busy in the next cycle
	`ASSERT_NEXT(a_query_busy, clk, arst_n, query_xfer, !req_ready)

endmodule

bind graph_hub_and_relay_query_top ghr_checker u_ghr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_kind       (req.kind),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_node_index (rsp.node_index),
	.rsp_found      (rsp.found),
	.rsp_score      (rsp.score)
);

FILE: bench/tb_graph_hub_and_relay_query_top.sv
// Self-checking bench for graph_hub_and_relay_query_top: edge writes, hub and relay queries.
// Depends on ghr_pkg, ghr_req_if, ghr_rsp_if and the block itself; runs directed rows, then
// random phases over several node counts; results match scripted answers or the bench model.
`timescale 1ns / 100ps

module tb_graph_hub_and_relay_query_top;
	import ghr_pkg::*;

	localparam int NODES         = 32;
	localparam int SETTLE_CYCLES = 8;     // lets an edge write in flight finish
	localparam int TAIL_CYCLES   = 1100;  // longer than a full-size hub query
	localparam int ITEMS_PER_SET = 40;
	localparam int HOLD_AT       = 60;    // result count that starts the long stall
	localparam int HOLD_CYCLES   = 400;
	localparam int STEADY_SET    = 6;     // random phase run with no idling
	// generous limit over the whole run, full-size hubs with stalls included
	localparam longint TIMEOUT_NS = 64'd12_000_000;

	// kind 3 has no package name; the block ignores it
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [NODE_W-1:0]  node_index;
		logic               found;
		logic [SCORE_W-1:0] score;
	} answer_t;

	typedef enum {ROW_ITEM, ROW_CFG} row_op_t;

	typedef struct {
		row_op_t             op;
		logic [KIND_W-1:0]   kind;
		logic [NODE_W-1:0]   a;
		logic [NODE_W-1:0]   b;
		logic [WEIGHT_W-1:0] w;      // node count for config rows
		bit                  typed;
		answer_t             ans;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	ghr_req_if req_ch ();
	ghr_rsp_if rsp_ch ();

	graph_hub_and_relay_query_top #(.MAX_NODES(NODES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Graph model state
	logic [WEIGHT_W-1:0] edge_weight [NODES][NODES];
	logic [CFG_W-1:0]    model_node_count;
	answer_t             pending_answers [$];
	int                  failures;
	bit                  steady;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Apply one item to the graph model; returns 1 when it yields a result
	function automatic bit resolve_item(input logic [KIND_W-1:0] kind,
			input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
			input logic [WEIGHT_W-1:0] w, output answer_t ans);
		int n;
		int cnt;
		logic [SCORE_W-1:0] sum;
		ans = '0;
		n = (model_node_count > NODES) ? NODES : model_node_count;
		case (kind)
			KIND_WRITE: begin
				edge_weight[a][b] = w;
				edge_weight[b][a] = w;
				return 1'b0;
			end
			KIND_HUB: begin
				for (int i = 0; i < n; i++) begin
					cnt = 0;
					for (int j = 0; j < n; j++)
						if (edge_weight[i][j] != 0)
							cnt++;
					if (cnt > ans.score) begin
						ans.score      = SCORE_W'(cnt);
						ans.node_index = NODE_W'(i);
						ans.found      = 1'b1;
					end
				end
				return 1'b1;
			end
			KIND_RELAY: begin
				for (int i = 0; i < n; i++) begin
					if (edge_weight[i][a] != 0 && edge_weight[i][b] != 0) begin
						sum = {1'b0, edge_weight[i][a]} + {1'b0, edge_weight[i][b]};
						if (!ans.found || sum < ans.score) begin
							ans.score      = sum;
							ans.node_index = NODE_W'(i);
							ans.found      = 1'b1;
						end
					end
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic row_t script_row(input row_op_t op, input logic [KIND_W-1:0] kind,
			input int a, input int b, input int w, input bit typed,
			input int node_index, input int found, input int score);
		row_t r;
		r.op             = op;
		r.kind           = kind;
		r.a              = NODE_W'(a);
		r.b              = NODE_W'(b);
		r.w              = WEIGHT_W'(w);
		r.typed          = typed;
		r.ans.node_index = NODE_W'(node_index);
		r.ans.found      = 1'(found);
		r.ans.score      = SCORE_W'(score);
		return r;
	endfunction

	function automatic logic [NODE_W-1:0] draw_node(input int span);
		if ($urandom_range(99) < 75)
			return NODE_W'($urandom_range(span - 1));
		return NODE_W'($urandom_range(NODES - 1));
	endfunction

	// Random item biased toward the scanned nodes so relays actually get found
	task automatic draw_item(output logic [KIND_W-1:0] kind, output logic [NODE_W-1:0] a,
			output logic [NODE_W-1:0] b, output logic [WEIGHT_W-1:0] w);
		int span;
		int r;
		span = model_node_count + 2;
		if (span < 3)
			span = 3;
		if (span > NODES)
			span = NODES;
		r = $urandom_range(99);
		if (r < 50)
			kind = KIND_WRITE;
		else if (r < 65)
			kind = KIND_HUB;
		else if (r < 95)
			kind = KIND_RELAY;
		else
			kind = KIND_UNUSED;
		a = draw_node(span);
		b = draw_node(span);
		r = $urandom_range(99);
		if (r < 10)
			w = '0;
		else if (r < 50)
			w = WEIGHT_W'($urandom_range(1, 4));
		else if (r < 60)
			w = WEIGHT_W'(16'hFFFF - $urandom_range(3));
		else
			w = WEIGHT_W'($urandom_range(16'hFFFF));
	endtask

	// Offer one item, with random idle cycles first; predict on transfer
	task automatic offer(input logic [KIND_W-1:0] kind, input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b, input logic [WEIGHT_W-1:0] w,
			input bit typed, input answer_t typed_ans);
		answer_t ans;
		while (!steady && $urandom_range(99) < 37) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.kind   <= kind;
		req_ch.node_a <= a;
		req_ch.node_b <= b;
		req_ch.weight <= w;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (resolve_item(kind, a, b, w, ans))
			pending_answers.push_back(typed ? typed_ans : ans);
	endtask

	// Drain all results, let any edge write finish, then write node_count
	task automatic load_node_count(input logic [CFG_W-1:0] value);
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_node_count = value;
	endtask

	// Stimulus
	initial begin
		row_t script [$];
		int plan [];
		logic [KIND_W-1:0]   kind;
		logic [NODE_W-1:0]   a;
		logic [NODE_W-1:0]   b;
		logic [WEIGHT_W-1:0] w;

		plan = '{32, 3, 9, 1, 16, 2, 6, 40, 12, 0, 5, 63, 20, 7};
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		req_ch.valid  = 1'b0;
		req_ch.kind   = KIND_WRITE;
		req_ch.node_a = '0;
		req_ch.node_b = '0;
		req_ch.weight = '0;
		steady        = 1'b0;
		failures      = 0;
		model_node_count = '0;
		foreach (edge_weight[i, j])
			edge_weight[i][j] = '0;

		//                          op        kind         a   b   w      typed idx f  score
		script.push_back(script_row(ROW_ITEM, KIND_HUB,    0,  0,  0,     1,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_RELAY,  0,  1,  0,     1,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_WRITE,  0,  1,  65535, 0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_HUB,    0,  0,  0,     1,    0,  0, 0));
		script.push_back(script_row(ROW_CFG,  KIND_WRITE,  0,  0,  63,    0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_HUB,    0,  0,  0,     1,    0,  1, 1));
		script.push_back(script_row(ROW_ITEM, KIND_WRITE,  2,  1,  65535, 0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_RELAY,  0,  2,  0,     1,    1,  1, 131070));
		script.push_back(script_row(ROW_ITEM, KIND_WRITE,  31, 31, 1,     0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_RELAY,  31, 31, 0,     1,    31, 1, 2));
		script.push_back(script_row(ROW_ITEM, KIND_HUB,    0,  0,  0,     1,    1,  1, 2));
		script.push_back(script_row(ROW_ITEM, KIND_UNUSED, 31, 31, 65535, 0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_WRITE,  1,  0,  0,     0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_RELAY,  0,  2,  0,     1,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_WRITE,  3,  0,  5,     0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_WRITE,  2,  3,  5,     0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_WRITE,  4,  0,  4,     0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_WRITE,  4,  2,  6,     0,    0,  0, 0));
		// equal sums through 3 and 4: lower node wins
		script.push_back(script_row(ROW_ITEM, KIND_RELAY,  0,  2,  0,     1,    3,  1, 10));
		script.push_back(script_row(ROW_CFG,  KIND_WRITE,  0,  0,  4,     0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_RELAY,  0,  2,  0,     0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_HUB,    0,  0,  0,     0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_RELAY,  31, 31, 0,     0,    0,  0, 0));
		script.push_back(script_row(ROW_CFG,  KIND_WRITE,  0,  0,  1,     0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_HUB,    0,  0,  0,     0,    0,  0, 0));
		script.push_back(script_row(ROW_CFG,  KIND_WRITE,  0,  0,  32,    0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_WRITE,  0,  0,  65535, 0,    0,  0, 0));
		script.push_back(script_row(ROW_ITEM, KIND_HUB,    0,  0,  0,     0,    0,  0, 0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows
		foreach (script[i]) begin
			if (script[i].op == ROW_CFG)
				load_node_count(script[i].w[CFG_W-1:0]);
			else
				offer(script[i].kind, script[i].a, script[i].b, script[i].w,
					script[i].typed, script[i].ans);
		end

		// Random phases, one node count each
		foreach (plan[p]) begin
			load_node_count(CFG_W'(plan[p]));
			steady = (p == STEADY_SET);
			repeat (ITEMS_PER_SET) begin
				draw_item(kind, a, b, w);
				offer(kind, a, b, w, 1'b0, '0);
			end
		end
		steady = 1'b0;

		// Drain, then watch for stray results
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Result side: check each transfer, drive ready with random stalls
	initial begin
		int hold_left;
		int results_seen;
		answer_t want;
		hold_left    = 0;
		results_seen = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (pending_answers.size() == 0) begin
					$error("unexpected result: node_index %0d found %0d score %0d",
						rsp_ch.node_index, rsp_ch.found, rsp_ch.score);
					failures++;
				end else begin
					want = pending_answers.pop_front();
					if (rsp_ch.node_index !== want.node_index) begin
						$error("node_index: expected %0d, got %0d",
							want.node_index, rsp_ch.node_index);
						failures++;
					end
					if (rsp_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp_ch.found);
						failures++;
					end
					if (rsp_ch.score !== want.score) begin
						$error("score: expected %0d, got %0d", want.score, rsp_ch.score);
						failures++;
					end
				end
				// long stall once, so the block backs up into its input
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(99) >= 37);
			end
		end
	end

	// Run limit
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end

endmodule
